// ----- rtl/core/hrf_pkg.sv -----
// Shared types, character constants and result codes of the HTTP request framer.
package hrf_pkg;

  localparam int unsigned KEY_LEN = 15;
  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Content-Length:";

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_S     = 8'h53;

  // Last three bytes before the final LF of a header end.
  localparam logic [23:0] HDR_END_TAIL = {CHAR_CR, CHAR_LF, CHAR_CR};

  // Size limit after reset, truncated to the length width where it is used.
  localparam logic [63:0] DEFAULT_MAX_FRAME = 64'd16777216;

  typedef enum logic [1:0] {
    STATUS_MORE       = 2'd0,
    STATUS_DONE       = 2'd1,
    STATUS_BAD_METHOD = 2'd2,
    STATUS_TOO_LARGE  = 2'd3
  } hrf_status_e;

  // One classified input beat, as handed from the front end to the engine.
  typedef struct packed {
    logic [7:0]  data;
    logic        is_digit;
    logic [3:0]  digit;
    logic        is_space;
    logic        is_lf;
    logic [15:0] key_hit;   // bit i: byte equals key character i; bit 15 never set
    logic        is_g;
    logic        is_e;
    logic        is_t;
    logic        is_p;
    logic        is_o;
    logic        is_s;
  } hrf_class_t;

  function automatic logic [7:0] key_char(input int unsigned idx);
    key_char = KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
  endfunction

endpackage

// ----- rtl/core/hrf_queue.sv -----
// Small FIFO built from flops: one push per cycle unless full, one pop unless empty.
module hrf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/hrf_front.sv -----
// Front end: classifies each incoming byte against the characters the framer looks for.
module hrf_front
  import hrf_pkg::*;
(
  input  logic [7:0] data_byte_i,
  output hrf_class_t class_o
);

  always_comb begin
    class_o          = '0;
    class_o.data     = data_byte_i;
    class_o.is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
    class_o.digit    = data_byte_i[3:0];
    class_o.is_space = (data_byte_i == CHAR_SPACE);
    class_o.is_lf    = (data_byte_i == CHAR_LF);
    class_o.is_g     = (data_byte_i == CHAR_G);
    class_o.is_e     = (data_byte_i == CHAR_E);
    class_o.is_t     = (data_byte_i == CHAR_T);
    class_o.is_p     = (data_byte_i == CHAR_P);
    class_o.is_o     = (data_byte_i == CHAR_O);
    class_o.is_s     = (data_byte_i == CHAR_S);
    for (int unsigned i = 0; i < KEY_LEN; i++) begin
      class_o.key_hit[i] = (data_byte_i == key_char(i));
    end
  end

endmodule

// ----- rtl/core/hrf_back.sv -----
// Framing engine: advances the request state one classified byte per cycle on take_i.
module hrf_back
  import hrf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  input  logic                   take_i,
  input  hrf_class_t             item_i,
  output hrf_status_e            status_o,
  output logic [LENGTH_BITS-1:0] frame_length_o,
  output logic                   method_o,
  output logic [LENGTH_BITS-1:0] body_length_o
);

  localparam logic [LENGTH_BITS-1:0] MaxReset = DEFAULT_MAX_FRAME[LENGTH_BITS-1:0];
  localparam logic [3:0]             KeyDone  = 4'(KEY_LEN);

  typedef enum logic [2:0] {
    MM_START, MM_G, MM_GE, MM_GET, MM_P, MM_PO, MM_POS, MM_POST
  } method_e;

  typedef enum logic [1:0] {
    LP_IDLE, LP_SKIP, LP_DIGITS, LP_DONE
  } phase_e;

  logic [LENGTH_BITS-1:0] max_q;
  logic [LENGTH_BITS-1:0] byte_count_q, byte_count_d;
  method_e                mm_q, mm_d;
  logic [23:0]            recent_q, recent_d;
  logic                   hdr_done_q, hdr_done_d;
  logic [LENGTH_BITS-1:0] hdr_len_q, hdr_len_d;
  logic [3:0]             key_pos_q, key_pos_d;
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] len_val_q, len_val_d;
  logic                   len_seen_q, len_seen_d;

  logic [LENGTH_BITS-1:0] count;
  logic                   method_ok;
  logic                   is_post;
  logic [LENGTH_BITS+3:0] times_ten;
  logic [3:0]             key_cand;
  logic [LENGTH_BITS:0]   end_pos;
  logic                   clear;

  always_comb begin
    count     = byte_count_q + 1'b1;
    method_ok = 1'b1;
    mm_d      = mm_q;

    unique case (mm_q)
      MM_START: begin
        if (item_i.is_g) begin
          mm_d = MM_G;
        end else if (item_i.is_p) begin
          mm_d = MM_P;
        end else begin
          method_ok = 1'b0;
        end
      end
      MM_G:   begin if (item_i.is_e) mm_d = MM_GE;   else method_ok = 1'b0; end
      MM_GE:  begin if (item_i.is_t) mm_d = MM_GET;  else method_ok = 1'b0; end
      MM_P:   begin if (item_i.is_o) mm_d = MM_PO;   else method_ok = 1'b0; end
      MM_PO:  begin if (item_i.is_s) mm_d = MM_POS;  else method_ok = 1'b0; end
      MM_POS: begin if (item_i.is_t) mm_d = MM_POST; else method_ok = 1'b0; end
      MM_GET, MM_POST: begin
        mm_d = mm_q;
      end
      default: method_ok = 1'b0;
    endcase
    is_post = (mm_d == MM_POST);

    phase_d    = phase_q;
    len_val_d  = len_val_q;
    key_pos_d  = key_pos_q;
    len_seen_d = len_seen_q;
    hdr_done_d = hdr_done_q;
    hdr_len_d  = hdr_len_q;
    times_ten  = {len_val_q, 3'b000} + {2'b00, len_val_q, 1'b0};
    times_ten  = times_ten + {{LENGTH_BITS{1'b0}}, item_i.digit};
    key_cand   = '0;

    if (!hdr_done_q) begin
      // Number after the key: skip spaces, accumulate digits, saturate at the limit.
      if (phase_q == LP_SKIP || phase_q == LP_DIGITS) begin
        if (item_i.is_digit) begin
          len_val_d = (times_ten > {4'b0000, max_q}) ? max_q : times_ten[LENGTH_BITS-1:0];
          phase_d   = LP_DIGITS;
        end else if (!(item_i.is_space && phase_q == LP_SKIP)) begin
          phase_d = LP_DONE;
        end
      end
      // Key search; only the first occurrence counts.
      if (!len_seen_q) begin
        if (key_pos_q < KeyDone && item_i.key_hit[key_pos_q]) begin
          key_cand = key_pos_q + 1'b1;
        end else begin
          key_cand = {3'b000, item_i.key_hit[0]};
        end
        key_pos_d = key_cand;
        if (key_cand == KeyDone) begin
          len_seen_d = 1'b1;
          phase_d    = LP_SKIP;
          len_val_d  = '0;
        end
      end
      if (recent_q == HDR_END_TAIL && item_i.is_lf) begin
        hdr_done_d = 1'b1;
        hdr_len_d  = count;
      end
    end
    recent_d     = {recent_q[15:0], item_i.data};
    byte_count_d = count;
    // Once the header is closed the length no longer moves, and the closing LF
    // is neither a digit nor a key end, so the held length is the final one.
    end_pos      = {1'b0, hdr_len_d} + {1'b0, len_val_q};

    clear          = 1'b1;
    frame_length_o = '0;
    body_length_o  = '0;
    method_o       = 1'b0;
    if (!method_ok) begin
      status_o = STATUS_BAD_METHOD;
    end else if (hdr_done_d && !is_post && mm_d == MM_GET) begin
      status_o       = STATUS_DONE;
      frame_length_o = count;
    end else if (hdr_done_d && is_post && len_seen_d && {1'b0, count} == end_pos) begin
      status_o       = STATUS_DONE;
      frame_length_o = count;
      method_o       = 1'b1;
      body_length_o  = len_val_q;
    end else if (count >= max_q) begin
      status_o = STATUS_TOO_LARGE;
      method_o = is_post;
    end else begin
      status_o = STATUS_MORE;
      method_o = is_post;
      clear    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q        <= MaxReset;
      byte_count_q <= '0;
      mm_q         <= MM_START;
      recent_q     <= '0;
      hdr_done_q   <= 1'b0;
      hdr_len_q    <= '0;
      key_pos_q    <= '0;
      phase_q      <= LP_IDLE;
      len_val_q    <= '0;
      len_seen_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (take_i) begin
        if (clear) begin
          byte_count_q <= '0;
          mm_q         <= MM_START;
          recent_q     <= '0;
          hdr_done_q   <= 1'b0;
          hdr_len_q    <= '0;
          key_pos_q    <= '0;
          phase_q      <= LP_IDLE;
          len_val_q    <= '0;
          len_seen_q   <= 1'b0;
        end else begin
          byte_count_q <= byte_count_d;
          mm_q         <= mm_d;
          recent_q     <= recent_d;
          hdr_done_q   <= hdr_done_d;
          hdr_len_q    <= hdr_len_d;
          key_pos_q    <= key_pos_d;
          phase_q      <= phase_d;
          len_val_q    <= len_val_d;
          len_seen_q   <= len_seen_d;
        end
      end
    end
  end

endmodule

// ----- rtl/core/http_request_framer_top.sv -----
// Top level of the HTTP request framer: front classifier, beat queues and framing engine.
//
// The framer takes a request stream one byte per beat and returns exactly one
// result beat per byte: status (0 need more, 1 frame complete, 2 unsupported
// method, 3 too large), frame length and body length on completion, and the
// method known so far. It runs at one byte per cycle sustained while the result queue
// has room; the figure is set by the framing engine, which folds one byte into the
// request state each cycle it takes a beat. A pushed byte is held in the classifier
// queue, folded in by the engine and registered in the result queue, whose oldest
// beat stays on the result ports until popped. Two-entry queues sit between the
// classifier and the engine and after the engine, so the input keeps taking bytes
// while a result waits to be popped; full rises once results back up and both
// queues hold two beats. max_frame_bytes resets to 16777216 and is written through
// cfg_we_i and cfg_wdata_i, by the user only while no result is outstanding (unenforced).
module http_request_framer_top
  import hrf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             data_byte_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             status_o,
  output logic [LENGTH_BITS-1:0] frame_length_o,
  output logic                   method_o,
  output logic [LENGTH_BITS-1:0] body_length_o
);

  localparam int unsigned ResW = 2 * LENGTH_BITS + 3;

  hrf_class_t             front_class;
  hrf_class_t             mid_class;
  logic                   mid_empty;
  logic                   res_full;
  logic                   take;
  hrf_status_e            eng_status;
  logic [LENGTH_BITS-1:0] eng_frame_len;
  logic                   eng_method;
  logic [LENGTH_BITS-1:0] eng_body_len;
  logic [ResW-1:0]        res_in;
  logic [ResW-1:0]        res_out;

  // Classify each byte as it is pushed.
  hrf_front u_front (
    .data_byte_i (data_byte_i),
    .class_o     (front_class)
  );

  // Hold classified beats until the engine takes them.
  hrf_queue #(
    .WIDTH ($bits(hrf_class_t)),
    .DEPTH (2)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_class),
    .full_o  (full),
    .pop_i   (take),
    .data_o  (mid_class),
    .empty_o (mid_empty)
  );

  // Advance the engine whenever a beat waits and its result has room.
  assign take = !mid_empty && !res_full;

  hrf_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .take_i         (take),
    .item_i         (mid_class),
    .status_o       (eng_status),
    .frame_length_o (eng_frame_len),
    .method_o       (eng_method),
    .body_length_o  (eng_body_len)
  );

  assign res_in = {eng_status, eng_frame_len, eng_method, eng_body_len};

  // Result queue: the oldest result stays on the ports until popped.
  hrf_queue #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o       = res_out[ResW-1 -: 2];
  assign frame_length_o = res_out[2*LENGTH_BITS : LENGTH_BITS+1];
  assign method_o       = res_out[LENGTH_BITS];
  assign body_length_o  = res_out[LENGTH_BITS-1:0];

endmodule

// ----- rtl/core/hrf_checker.sv -----
// Port-level checker of the HTTP request framer and its bind to the top level.
module hrf_checker
  import hrf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 25
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   empty,
  input logic                   pop,
  input logic [1:0]             status_o,
  input logic [LENGTH_BITS-1:0] frame_length_o,
  input logic                   method_o,
  input logic [LENGTH_BITS-1:0] body_length_o
);

  localparam logic [LENGTH_BITS:0] MinFrame = (LENGTH_BITS+1)'(7);

  logic [LENGTH_BITS:0] body_plus_min;
  assign body_plus_min = {1'b0, body_length_o} + MinFrame;

  // A waiting result beat holds until popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(frame_length_o)
                          && $stable(method_o) && $stable(body_length_o)))
    else $error("result beat changed while waiting");

  // A completed frame spans its header of at least seven bytes plus its body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_DONE) |-> ({1'b0, frame_length_o} >= body_plus_min))
    else $error("frame length shorter than header plus body");

  // Lengths are reported only on completion, and a body only for POST.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != STATUS_DONE || !method_o))
      |-> (body_length_o == '0 && (status_o == STATUS_DONE || frame_length_o == '0)))
    else $error("length reported outside a completed frame");

  // A method error carries no method.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_BAD_METHOD) |-> !method_o)
    else $error("method set on unsupported method error");

endmodule

bind http_request_framer_top hrf_checker #(
  .LENGTH_BITS (LENGTH_BITS)
) u_hrf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .status_o       (status_o),
  .frame_length_o (frame_length_o),
  .method_o       (method_o),
  .body_length_o  (body_length_o)
);

// ----- tb/http_request_framer_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the HTTP request framer: byte stream in, framing status out.
module http_request_framer_top_tb;
  import hrf_pkg::*;

  localparam int unsigned LEN_W       = 25;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [LEN_W-1:0] RESET_LIMIT = 25'd16777216;
  localparam logic [LEN_W-1:0] WIDEST_LIMIT = '1;

  // Progress through the method word.
  localparam logic [2:0] MM_IDLE = 3'd0;
  localparam logic [2:0] MM_G    = 3'd1;
  localparam logic [2:0] MM_GE   = 3'd2;
  localparam logic [2:0] MM_GET  = 3'd3;
  localparam logic [2:0] MM_P    = 3'd4;
  localparam logic [2:0] MM_PO   = 3'd5;
  localparam logic [2:0] MM_POS  = 3'd6;
  localparam logic [2:0] MM_POST = 3'd7;

  // Where the length number parse stands.
  localparam logic [1:0] LP_WAIT   = 2'd0;
  localparam logic [1:0] LP_SPACES = 2'd1;
  localparam logic [1:0] LP_DIGITS = 2'd2;
  localparam logic [1:0] LP_DONE   = 2'd3;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_X   = 8'h78;

  // One result beat as the framer should return it.
  typedef struct packed {
    hrf_status_e      status;
    logic [LEN_W-1:0] frame_len;
    logic             method;
    logic [LEN_W-1:0] body_len;
  } frame_result_t;

  // Tracks the request being framed and holds the result beats still owed.
  class frame_scoreboard;
    logic [LEN_W-1:0] size_limit;
    logic [LEN_W-1:0] bytes_taken;
    logic [2:0]       method_prog;
    logic [23:0]      last_three;
    bit               hdr_seen;
    logic [LEN_W-1:0] hdr_bytes;
    int unsigned      key_matched;
    logic [1:0]       len_phase;
    logic [LEN_W-1:0] body_bytes;
    bit               key_seen;
    bit               post_req;
    frame_result_t    due_results[$];
    int unsigned      mismatches;
    string            key_word;

    function new();
      size_limit = RESET_LIMIT;
      mismatches = 0;
      key_word   = "Content-Length:";
      restart();
    endfunction

    function void restart();
      bytes_taken = '0;
      method_prog = MM_IDLE;
      last_three  = '0;
      hdr_seen    = 1'b0;
      hdr_bytes   = '0;
      key_matched = 0;
      len_phase   = LP_WAIT;
      body_bytes  = '0;
      key_seen    = 1'b0;
      post_req    = 1'b0;
    endfunction

    function void set_limit(logic [LEN_W-1:0] v);
      size_limit = v;
    endfunction

    function int unsigned waiting();
      return due_results.size();
    endfunction

    function void queue_result(hrf_status_e st, logic [31:0] flen, logic meth,
                               logic [LEN_W-1:0] blen);
      frame_result_t r;
      r.status    = st;
      r.frame_len = flen[LEN_W-1:0];
      r.method    = meth;
      r.body_len  = blen;
      due_results.push_back(r);
    endfunction

    // Fold one accepted byte into the request and owe its result beat.
    function void absorb_byte(logic [7:0] b);
      logic [31:0]      cnt;
      logic [31:0]      acc;
      logic [LEN_W-1:0] blen;
      bit               method_ok;
      cnt = 32'(bytes_taken) + 32'd1;
      method_ok = 1'b1;
      case (method_prog)
        MM_IDLE: begin
          if (b == CHAR_G) method_prog = MM_G;
          else if (b == CHAR_P) method_prog = MM_P;
          else method_ok = 1'b0;
        end
        MM_G:   if (b == CHAR_E) method_prog = MM_GE; else method_ok = 1'b0;
        MM_GE:  if (b == CHAR_T) method_prog = MM_GET; else method_ok = 1'b0;
        MM_P:   if (b == CHAR_O) method_prog = MM_PO; else method_ok = 1'b0;
        MM_PO:  if (b == CHAR_S) method_prog = MM_POS; else method_ok = 1'b0;
        MM_POS: begin
          if (b == CHAR_T) begin
            method_prog = MM_POST;
            post_req = 1'b1;
          end else begin
            method_ok = 1'b0;
          end
        end
        default: ;
      endcase
      if (!method_ok) begin
        restart();
        queue_result(STATUS_BAD_METHOD, '0, 1'b0, '0);
        return;
      end

      if (!hdr_seen) begin
        if (len_phase == LP_SPACES || len_phase == LP_DIGITS) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            acc = 32'(body_bytes) * 32'd10 + 32'(b - CHAR_ZERO);
            body_bytes = (acc > 32'(size_limit)) ? size_limit : acc[LEN_W-1:0];
            len_phase = LP_DIGITS;
          end else if (!(b == CHAR_SPACE && len_phase == LP_SPACES)) begin
            len_phase = LP_DONE;
          end
        end
        if (!key_seen) begin
          if (key_matched < KEY_LEN && b == 8'(key_word[key_matched])) key_matched++;
          else key_matched = (b == 8'(key_word[0])) ? 1 : 0;
          if (key_matched == KEY_LEN) begin
            key_seen   = 1'b1;
            len_phase  = LP_SPACES;
            body_bytes = '0;
          end
        end
        if (last_three == HDR_END_TAIL && b == CHAR_LF) begin
          hdr_seen  = 1'b1;
          hdr_bytes = cnt[LEN_W-1:0];
        end
      end
      last_three  = {last_three[15:0], b};
      bytes_taken = cnt[LEN_W-1:0];

      if (hdr_seen) begin
        if (!post_req && method_prog == MM_GET) begin
          restart();
          queue_result(STATUS_DONE, cnt, 1'b0, '0);
          return;
        end
        if (post_req && key_seen && cnt == 32'(hdr_bytes) + 32'(body_bytes)) begin
          blen = body_bytes;
          restart();
          queue_result(STATUS_DONE, cnt, 1'b1, blen);
          return;
        end
      end

      if (cnt >= 32'(size_limit)) begin
        acc[0] = post_req;
        restart();
        queue_result(STATUS_TOO_LARGE, '0, acc[0], '0);
        return;
      end
      queue_result(STATUS_MORE, '0, post_req, '0);
    endfunction

    function void compare(string name, logic [LEN_W-1:0] want_v, logic [LEN_W-1:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    // Match a popped beat against the oldest owed result.
    function void check_beat(logic [1:0] st, logic [LEN_W-1:0] flen, logic meth,
                             logic [LEN_W-1:0] blen);
      frame_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual status %0d frame %0d",
                 $time, st, flen);
        return;
      end
      want = due_results.pop_front();
      compare("status", LEN_W'(want.status), LEN_W'(st));
      compare("frame_length", want.frame_len, flen);
      compare("method", LEN_W'(want.method), LEN_W'(meth));
      compare("body_length", want.body_len, blen);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  logic             push;
  logic             full;
  logic [7:0]       data_byte;
  logic             empty;
  logic             pop;
  logic [1:0]       status;
  logic [LEN_W-1:0] frame_length;
  logic             method;
  logic [LEN_W-1:0] body_length;

  frame_scoreboard  sb;
  bit               tx_idle_on;
  bit               rx_idle_on;
  logic [7:0]       req_q[$];
  logic [LEN_W-1:0] cur_limit;
  int unsigned      cycle_cnt;

  http_request_framer_top #(.LENGTH_BITS(LEN_W)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status),
    .frame_length_o(frame_length),
    .method_o      (method),
    .body_length_o (body_length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: abort a run that hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, sb.waiting());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte after a random gap; hold it until the framer takes the beat.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (full);
    sb.absorb_byte(b);
  endtask

  task automatic send_request();
    foreach (req_q[i]) send_byte(req_q[i]);
  endtask

  // Stall a random number of cycles, then take one result beat and check it.
  task automatic take_result();
    int unsigned stall;
    stall = rx_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (stall != 0) begin
      pop <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    pop <= 1'b1;
    do @(posedge clk); while (empty);
    sb.check_beat(status, frame_length, method, body_length);
  endtask

  // Drop push and hold off until every owed result has been popped.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
    cur_limit = v;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) req_q.push_back(8'(s[i]));
  endtask

  task automatic add_crlf();
    req_q.push_back(CHAR_CR);
    req_q.push_back(CHAR_LF);
  endtask

  // Harmless header line; now and then a lowercase key that must not match.
  task automatic add_filler_header();
    if ($urandom_range(0, 7) == 0) begin
      add_text("content-length: 12");
    end else begin
      add_text("X-");
      repeat ($urandom_range(1, 6)) req_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      add_text(": ");
      repeat ($urandom_range(0, 8)) req_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    add_crlf();
  endtask

  // Length header in its many spellings; returns the value written out.
  task automatic add_length_header(input bit tight, output int unsigned len_num);
    int unsigned form;
    len_num = 0;
    form = $urandom_range(0, 9);
    if (form == 0) add_text("CContent-Length:");
    else if (form == 1) add_text("Content-Content-Length:");
    else add_text("Content-Length:");
    repeat ($urandom_range(0, 3)) req_q.push_back(CHAR_SPACE);
    form = $urandom_range(0, 11);
    if (form == 0) begin
      // no digits at all: the number ends at once with length zero
      req_q.push_back($urandom_range(0, 1) ? CHAR_TAB : CHAR_X);
    end else if (tight && form == 1) begin
      // far past the limit: the parse saturates
      add_text("999999999");
      len_num = 999999999;
    end else begin
      len_num = (tight && form == 2) ? $urandom_range(0, cur_limit) : $urandom_range(0, 40);
      if (form == 3) req_q.push_back(CHAR_ZERO);
      add_text($sformatf("%0d", len_num));
      if (form == 4) req_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_X);
    end
    add_crlf();
    // a second key is ignored, only the first one counts
    if ($urandom_range(0, 7) == 0) begin
      add_text("Content-Length: 3");
      add_crlf();
    end
  endtask

  // Build one request: mostly well formed, some noise, broken methods and cut frames.
  task automatic make_request();
    int unsigned pick;
    int unsigned n_hdr;
    int unsigned key_at;
    int unsigned i;
    int unsigned body_n;
    int unsigned len_num;
    int unsigned cut;
    bit          post_req;
    bit          with_key;
    bit          tight;
    tight   = (cur_limit <= 4096);
    len_num = 0;
    req_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      repeat ($urandom_range(1, 6)) req_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 14) begin
      case ($urandom_range(0, 4))
        0: add_text("G");
        1: add_text("GE");
        2: add_text("P");
        3: add_text("PO");
        default: add_text("POS");
      endcase
      req_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    post_req = 1'($urandom_range(0, 1));
    add_text(post_req ? "POST /" : "GET /");
    repeat ($urandom_range(0, 8)) req_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    add_text(" HTTP/1.1");
    add_crlf();
    // without a key a POST waits for the size limit, so keep it to small limits
    with_key = post_req ? (!tight || $urandom_range(0, 7) != 0) : ($urandom_range(0, 4) == 0);
    n_hdr  = $urandom_range(0, 3);
    key_at = $urandom_range(0, n_hdr);
    for (i = 0; i <= n_hdr; i++) begin
      if (with_key && i == key_at) add_length_header(tight, len_num);
      if (i < n_hdr) add_filler_header();
    end
    add_crlf();
    if (post_req && with_key) begin
      body_n = (len_num > 200) ? 200 : len_num;
      i = 0;
      // key text in the body must be ignored
      if (body_n >= 17 && $urandom_range(0, 5) == 0) begin
        add_text("Content-Length: 9");
        i = 17;
      end
      while (i < body_n) begin
        req_q.push_back(8'($urandom_range(0, 255)));
        i++;
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, req_q.size());
      while (req_q.size() > cut) void'(req_q.pop_back());
    end
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      make_request();
      // mostly idle at random on both sides, with bursts at full rate
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 24) == 0) wait_idle();
      send_request();
      sent += req_q.size();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    push       = 1'b0;
    data_byte  = '0;
    pop        = 1'b0;
    cycle_cnt  = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    cur_limit  = RESET_LIMIT;
    sb = new();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      forever take_result();
    join_none

    // Smallest GET, then bad first bytes at both ends of the range and a POST gone wrong.
    req_q.delete();
    add_text("GET");
    add_crlf();
    add_crlf();
    req_q.push_back(8'h00);
    req_q.push_back(8'hFF);
    add_text("POX");
    send_request();
    run_random(300);

    // Smallest legal limit: a completion on the limit byte wins over too large.
    write_limit(25'd8);
    req_q.delete();
    add_text("GETx");
    add_crlf();
    add_crlf();
    send_request();
    run_random(80);

    // Limits below range reject every first byte.
    write_limit(25'd0);
    req_q.delete();
    add_text("GP");
    send_request();
    write_limit(25'd1);
    req_q.delete();
    add_text("PX");
    send_request();

    write_limit(WIDEST_LIMIT);
    run_random(250);

    repeat (4) begin
      write_limit(25'($urandom_range(24, 400)));
      run_random(230);
    end

    write_limit(RESET_LIMIT);
    run_random(200);

    // Drain, then give stray beats time to show up.
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
